// ===== design/dda_pkg.sv =====
`default_nettype none
package dda_pkg;

    localparam int MAP_SIZE = 64;
    localparam int MAP_BITS = $clog2(MAP_SIZE);
    localparam int ADDR_W   = $clog2(MAP_SIZE * MAP_SIZE);
    // signed tile coordinate, room for -1 and for the 6 bit player tile
    localparam int TC_W     = ((MAP_BITS > 6) ? MAP_BITS : 6) + 2;

    localparam int DIV_W    = 31;
    localparam int DCNT_W   = $clog2(DIV_W);
    localparam int TOT_W    = 40;

    localparam int IN_W     = 32;
    localparam int OUT_W    = 72;
    localparam int CIDX_W   = 4;
    localparam int CDAT_W   = 22;

    localparam logic [CIDX_W-1:0] CFG_PLAYER_X = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_PLAYER_Y = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_DIR_X    = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_DIR_Y    = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_PLANE_X  = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_PLANE_Y  = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_SCR_W    = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_SCR_H    = 4'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [21:0] RST_PLAYER_X = 22'd2097152;
    localparam logic [21:0] RST_PLAYER_Y = 22'd2097152;
    localparam logic [15:0] RST_DIR_X    = 16'd16384;
    localparam logic [15:0] RST_DIR_Y    = 16'd0;
    localparam logic [15:0] RST_PLANE_X  = 16'd0;
    localparam logic [15:0] RST_PLANE_Y  = 16'd10813;
    localparam logic [10:0] RST_SCR_W    = 11'd640;
    localparam logic [10:0] RST_SCR_H    = 11'd480;

    localparam logic [63:0] BRIGHT_DEN = 64'(MAP_SIZE * MAP_SIZE) << 24;
    localparam logic [25:0] FALLOFF_T0 = 26'(MAP_SIZE + 1) << 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCAM,
        S_MPX,
        S_MPY,
        S_RAY,
        S_DDX,
        S_DDY,
        S_MTX,
        S_MTY,
        S_TOT,
        S_STEP,
        S_CHK,
        S_HLD,
        S_DHGT,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== design/dda_grid_raycast_column.sv =====
`default_nettype none
// channel   direction  handshake               payload
// s         in         i_s_tvalid/o_s_tready   i_s_tdata (tile/column), i_s_tuser (action)
// m         out        o_m_tvalid/i_m_tready   o_m_tdata (cast result)
// cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A cast runs four 31-step divisions (camera x, two deltas, wall height) on
// one restoring divider, six products on one 32x32 multiplier, and a map read
// per grid cell walked. The map is undefined after reset until written; no
// clearing pass. A finished word waits in the output register while the
// next item is taken.
module dda_grid_raycast_column (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_tvalid,
    output logic                           o_s_tready,
    // [5:0] tile_x, [11:6] tile_y, [19:12] tile_value, [29:20] column
    input  wire logic [dda_pkg::IN_W-1:0]  i_s_tdata,
    // [0] action
    input  wire logic                      i_s_tuser,
    output logic                           o_m_tvalid,
    input  wire logic                      i_m_tready,
    // [9:0] column_out, [17:10] wall_type, [18] hit_side, [42:19] distance,
    // [53:43] wall_height, [61:54] tex_coord, [70:62] brightness, [71] out_of_map
    output logic [dda_pkg::OUT_W-1:0]      o_m_tdata,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [dda_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic [dda_pkg::CDAT_W-1:0] i_cfg_data
);

    localparam int DW  = dda_pkg::DIV_W;
    localparam int TCW = dda_pkg::TC_W;
    localparam int TW  = dda_pkg::TOT_W;
    localparam int AW  = dda_pkg::ADDR_W;

    dda_pkg::t_state r_state, n_state;

    logic [21:0] r_player_x, r_player_y;
    logic [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0] r_scr_w, r_scr_h;

    logic [7:0] r_map [dda_pkg::MAP_SIZE * dda_pkg::MAP_SIZE];
    logic [7:0] r_rd;

    // divider
    logic [DW-1:0]                r_dnum, r_drem, r_dden;
    logic [dda_pkg::DCNT_W-1:0]   r_dcnt;
    logic [DW:0]                  dv_sh;
    logic                         dv_ge;
    logic [DW-1:0]                dv_rem_n, dv_num_n;
    logic                         dv_last;

    // multiplier
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] r_prod;

    logic [9:0]               r_col;
    logic signed [28:0]       r_camx;
    logic signed [29:0]       r_rx, r_ry;
    logic [30:0]              r_dx, r_dy;
    logic [TW-1:0]            r_totx, r_toty;
    logic signed [TCW-1:0]    r_tx, r_ty;
    logic                     r_side, r_out;
    logic [7:0]               r_wall;
    logic [23:0]              r_dist;
    logic [7:0]               r_tex;
    logic [10:0]              r_hgt;
    logic [8:0]               r_bright;

    logic                     r_ovalid;
    logic [dda_pkg::OUT_W-1:0] r_odata;

    logic        s_acc, w_acc, c_acc, cfg_acc;
    logic [5:0]  in_tx, in_ty;
    logic [7:0]  in_val;
    logic [9:0]  in_col;
    logic        vx, vy, take_x, step_out, cast_out, out_free;
    logic signed [TCW-1:0] nx, ny, ptx, pty;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [16:0] frac_x, frac_y;
    logic [30:0] abs_rx, abs_ry;
    logic [TW-1:0] dist_full;
    logic [23:0] dist_c;
    logic [24:0] hden;
    logic [25:0] t_s, t_abs;
    logic [15:0] hit16;
    logic [63:0] bright_full;
    logic [8:0]  bright;
    logic [10:0] scr_w_eff;

    assign in_tx  = i_s_tdata[5:0];
    assign in_ty  = i_s_tdata[11:6];
    assign in_val = i_s_tdata[19:12];
    assign in_col = i_s_tdata[29:20];

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign w_acc   = s_acc && (i_s_tuser == dda_pkg::ACT_WRITE);
    assign c_acc   = s_acc && (i_s_tuser == dda_pkg::ACT_CAST);
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_ovalid || i_m_tready;

    // ---------------- shared divider step ----------------
    always_comb begin
        dv_sh    = {r_drem, r_dnum[DW-1]};
        dv_ge    = dv_sh >= {1'b0, r_dden};
        dv_rem_n = dv_ge ? DW'(dv_sh - {1'b0, r_dden}) : dv_sh[DW-1:0];
        dv_num_n = {r_dnum[DW-2:0], dv_ge};
        dv_last  = (r_dcnt == dda_pkg::DCNT_W'(DW - 1));
    end

    // ---------------- ray and walk helpers ----------------
    always_comb begin
        vx       = (r_rx != '0);
        vy       = (r_ry != '0);
        abs_rx   = r_rx[29] ? 31'(-32'(r_rx)) : 31'(r_rx);
        abs_ry   = r_ry[29] ? 31'(-32'(r_ry)) : 31'(r_ry);
        frac_x   = (r_rx > 0) ? 17'(17'd65536 - {1'b0, r_player_x[15:0]})
                              : {1'b0, r_player_x[15:0]};
        frac_y   = (r_ry > 0) ? 17'(17'd65536 - {1'b0, r_player_y[15:0]})
                              : {1'b0, r_player_y[15:0]};
        ptx      = TCW'(r_player_x[21:16]);
        pty      = TCW'(r_player_y[21:16]);
        cast_out = (!vx && !vy) || (ptx >= TCW'(dda_pkg::MAP_SIZE))
                   || (pty >= TCW'(dda_pkg::MAP_SIZE));
        take_x   = vx && (!vy || (r_totx < r_toty));
        nx       = r_tx;
        ny       = r_ty;
        if (take_x) begin
            nx = (r_rx > 0) ? r_tx + TCW'(1) : r_tx - TCW'(1);
        end else begin
            ny = (r_ry > 0) ? r_ty + TCW'(1) : r_ty - TCW'(1);
        end
        step_out = (nx < 0) || (ny < 0) || (nx >= TCW'(dda_pkg::MAP_SIZE))
                   || (ny >= TCW'(dda_pkg::MAP_SIZE));
        rd_addr  = AW'(AW'(ny[TCW-2:0]) * AW'(dda_pkg::MAP_SIZE) + AW'(nx[TCW-2:0]));
        wr_addr  = AW'(AW'(in_ty) * AW'(dda_pkg::MAP_SIZE) + AW'(in_tx));
        dist_full = r_side ? TW'(r_toty - TW'(r_dy)) : TW'(r_totx - TW'(r_dx));
        dist_c    = (dist_full > TW'(24'hFFFFFF)) ? 24'hFFFFFF : dist_full[23:0];
        hden      = (r_dist > 24'd65536) ? {1'b0, r_dist} : 25'd65536;
        t_s       = 26'(dda_pkg::FALLOFF_T0 - {2'b0, r_dist});
        t_abs     = t_s[25] ? 26'(-t_s) : t_s;
        hit16     = 16'((r_side ? r_player_x[15:0] : r_player_y[15:0]) + r_prod[29:14]);
        bright_full = 64'(r_prod) / dda_pkg::BRIGHT_DEN;
        bright    = (bright_full > 64'd256) ? 9'd256 : bright_full[8:0];
        scr_w_eff = (r_scr_w == '0) ? 11'd1 : r_scr_w;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dda_pkg::S_IDLE: if (c_acc) n_state = dda_pkg::S_DCAM;
            dda_pkg::S_DCAM: if (dv_last) n_state = dda_pkg::S_MPX;
            dda_pkg::S_MPX:  n_state = dda_pkg::S_MPY;
            dda_pkg::S_MPY:  n_state = dda_pkg::S_RAY;
            dda_pkg::S_RAY:  n_state = dda_pkg::S_DDX;
            dda_pkg::S_DDX:  if (dv_last) n_state = dda_pkg::S_DDY;
            dda_pkg::S_DDY:  if (dv_last) n_state = dda_pkg::S_MTX;
            dda_pkg::S_MTX:  n_state = dda_pkg::S_MTY;
            dda_pkg::S_MTY:  n_state = dda_pkg::S_TOT;
            dda_pkg::S_TOT:  n_state = cast_out ? dda_pkg::S_FIN : dda_pkg::S_STEP;
            dda_pkg::S_STEP: n_state = step_out ? dda_pkg::S_FIN : dda_pkg::S_CHK;
            dda_pkg::S_CHK:  n_state = (r_rd != '0) ? dda_pkg::S_HLD : dda_pkg::S_STEP;
            dda_pkg::S_HLD:  n_state = dda_pkg::S_DHGT;
            dda_pkg::S_DHGT: if (dv_last) n_state = dda_pkg::S_FIN;
            dda_pkg::S_FIN:  if (out_free) n_state = dda_pkg::S_IDLE;
            default:         n_state = dda_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs and multiplier operands ----------------
    always_comb begin
        o_s_tready  = (r_state == dda_pkg::S_IDLE);
        o_cfg_ready = 1'b1;
        o_m_tvalid  = r_ovalid;
        o_m_tdata   = r_odata;
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            dda_pkg::S_MPX: begin
                m_a = 32'(signed'(r_plane_x));
                m_b = 32'(r_camx);
            end
            dda_pkg::S_MPY: begin
                m_a = 32'(signed'(r_plane_y));
                m_b = 32'(r_camx);
            end
            dda_pkg::S_MTX: begin
                m_a = signed'({15'd0, frac_x});
                m_b = signed'({1'b0, r_dx});
            end
            dda_pkg::S_MTY: begin
                m_a = signed'({15'd0, frac_y});
                m_b = signed'({1'b0, r_dy});
            end
            dda_pkg::S_HLD: begin
                m_a = 32'(r_side ? r_rx : r_ry);
                m_b = signed'({8'd0, r_dist});
            end
            dda_pkg::S_DHGT: begin
                m_a = signed'({6'd0, t_abs});
                m_b = signed'({6'd0, t_abs});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dda_pkg::S_IDLE;
            r_ovalid   <= 1'b0;
            r_player_x <= dda_pkg::RST_PLAYER_X;
            r_player_y <= dda_pkg::RST_PLAYER_Y;
            r_dir_x    <= dda_pkg::RST_DIR_X;
            r_dir_y    <= dda_pkg::RST_DIR_Y;
            r_plane_x  <= dda_pkg::RST_PLANE_X;
            r_plane_y  <= dda_pkg::RST_PLANE_Y;
            r_scr_w    <= dda_pkg::RST_SCR_W;
            r_scr_h    <= dda_pkg::RST_SCR_H;
        end else begin
            r_state <= n_state;
            if (r_state == dda_pkg::S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    dda_pkg::CFG_PLAYER_X: r_player_x <= i_cfg_data;
                    dda_pkg::CFG_PLAYER_Y: r_player_y <= i_cfg_data;
                    dda_pkg::CFG_DIR_X:    r_dir_x    <= i_cfg_data[15:0];
                    dda_pkg::CFG_DIR_Y:    r_dir_y    <= i_cfg_data[15:0];
                    dda_pkg::CFG_PLANE_X:  r_plane_x  <= i_cfg_data[15:0];
                    dda_pkg::CFG_PLANE_Y:  r_plane_y  <= i_cfg_data[15:0];
                    dda_pkg::CFG_SCR_W:    r_scr_w    <= i_cfg_data[10:0];
                    dda_pkg::CFG_SCR_H:    r_scr_h    <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- tile map ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc && (7'(in_tx) < 7'(dda_pkg::MAP_SIZE))
                  && (7'(in_ty) < 7'(dda_pkg::MAP_SIZE))) begin
            r_map[wr_addr] <= in_val;
        end
        if (r_state == dda_pkg::S_STEP) begin
            r_rd <= r_map[rd_addr];
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        // the last delta-x step reloads the divider below instead
        if (r_state == dda_pkg::S_DCAM || (r_state == dda_pkg::S_DDX && !dv_last)
            || r_state == dda_pkg::S_DDY || r_state == dda_pkg::S_DHGT) begin
            r_dnum <= dv_num_n;
            r_drem <= dv_rem_n;
            r_dcnt <= r_dcnt + dda_pkg::DCNT_W'(1);
        end
        unique case (r_state)
            dda_pkg::S_IDLE: begin
                if (c_acc) begin
                    r_col  <= in_col;
                    r_out  <= 1'b0;
                    r_wall <= '0;
                    r_side <= 1'b0;
                    r_dnum <= DW'({in_col, 17'd0});
                    r_drem <= '0;
                    r_dden <= DW'(scr_w_eff);
                    r_dcnt <= '0;
                end
            end
            dda_pkg::S_DCAM: begin
                if (dv_last) begin
                    r_camx <= 29'(signed'({1'b0, dv_num_n[27:0]}) - 29'sd65536);
                end
            end
            dda_pkg::S_MPY: r_rx <= 30'(signed'(r_dir_x)) + r_prod[45:16];
            dda_pkg::S_RAY: begin
                r_ry   <= 30'(signed'(r_dir_y)) + r_prod[45:16];
                r_dnum <= DW'(1) << 30;
                r_drem <= '0;
                r_dden <= abs_rx;
                r_dcnt <= '0;
            end
            dda_pkg::S_DDX: begin
                if (dv_last) begin
                    r_dx   <= dv_num_n;
                    r_dnum <= DW'(1) << 30;
                    r_drem <= '0;
                    r_dden <= abs_ry;
                    r_dcnt <= '0;
                end
            end
            dda_pkg::S_DDY: if (dv_last) r_dy <= dv_num_n;
            dda_pkg::S_MTY: r_totx <= vx ? TW'(r_prod[47:16]) : '0;
            dda_pkg::S_TOT: begin
                r_toty <= vy ? TW'(r_prod[47:16]) : '0;
                r_tx   <= ptx;
                r_ty   <= pty;
                if (cast_out) r_out <= 1'b1;
            end
            dda_pkg::S_STEP: begin
                if (take_x) begin
                    r_totx <= TW'(r_totx + TW'(r_dx));
                    r_side <= 1'b0;
                end else begin
                    r_toty <= TW'(r_toty + TW'(r_dy));
                    r_side <= 1'b1;
                end
                r_tx <= nx;
                r_ty <= ny;
                if (step_out) r_out <= 1'b1;
            end
            dda_pkg::S_CHK: begin
                r_wall <= r_rd;
                r_dist <= dist_c;
            end
            dda_pkg::S_HLD: begin
                r_dnum <= DW'({r_scr_h, 16'd0});
                r_drem <= '0;
                r_dden <= DW'(hden);
                r_dcnt <= '0;
            end
            dda_pkg::S_DHGT: begin
                // first cycle holds the hit product, later ones the falloff square
                if (r_dcnt == '0) r_tex <= hit16[15:8];
                if (dv_last) begin
                    r_hgt    <= dv_num_n[10:0];
                    r_bright <= bright;
                end
            end
            dda_pkg::S_FIN: begin
                if (out_free) begin
                    r_odata[9:0] <= r_col;
                    r_odata[71]  <= r_out;
                    if (r_out) begin
                        r_odata[70:10] <= '0;
                    end else begin
                        r_odata[17:10] <= r_wall;
                        r_odata[18]    <= r_side;
                        r_odata[42:19] <= r_dist;
                        r_odata[53:43] <= r_hgt;
                        r_odata[61:54] <= r_tex;
                        r_odata[70:62] <= r_bright;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/dda_chk.sv =====
`default_nettype none
module dda_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_s_tvalid,
    input wire logic                       o_s_tready,
    input wire logic                       i_s_tuser,
    input wire logic                       o_m_tvalid,
    input wire logic                       i_m_tready,
    input wire logic [dda_pkg::OUT_W-1:0]  o_m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // a cast keeps the input side closed while it walks
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == dda_pkg::ACT_CAST) |=> !o_s_tready)
        else $error("input taken during a cast");

    // a ray that left the map reports no hit
    a_oom_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[71] |-> (o_m_tdata[70:10] == '0))
        else $error("out of map word carries hit data");

    // brightness is capped at one
    a_bright_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[70:62] <= 9'd256))
        else $error("brightness above cap");

endmodule

bind dda_grid_raycast_column dda_chk u_dda_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic       act;
        logic [5:0] tx;
        logic [5:0] ty;
        logic [7:0] val;
        logic [9:0] col;
    } t_cmd;

    // walled room that keeps every ray on written tiles
    localparam int ROOM_LO = 24;
    localparam int ROOM_HI = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [dda_pkg::IN_W-1:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic i_m_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [dda_pkg::CIDX_W-1:0] i_cfg_index = '0;
    logic [dda_pkg::CDAT_W-1:0] i_cfg_data = '0;
    wire o_s_tready, o_m_tvalid, o_cfg_ready;
    wire [dda_pkg::OUT_W-1:0] o_m_tdata;

    dda_grid_raycast_column uut (.*);

    always #10 i_clk = ~i_clk;

    // shadow of the block's registers and map
    logic [21:0] px = dda_pkg::RST_PLAYER_X, py = dda_pkg::RST_PLAYER_Y;
    logic signed [15:0] dirx = dda_pkg::RST_DIR_X, diry = dda_pkg::RST_DIR_Y;
    logic signed [15:0] plx = dda_pkg::RST_PLANE_X, ply = dda_pkg::RST_PLANE_Y;
    logic [10:0] scr_w = dda_pkg::RST_SCR_W, scr_h = dda_pkg::RST_SCR_H;
    logic [7:0] tiles [dda_pkg::MAP_SIZE*dda_pkg::MAP_SIZE];

    t_cmd cmd_q[$];
    logic [dda_pkg::OUT_W-1:0] hit_q[$];
    int errors = 0;
    bit no_idle = 0;
    bit hold_req = 0;
    bit hold_seen = 0;
    int hold_cnt = 0;
    int fld_lo [8] = '{0, 10, 18, 19, 43, 54, 62, 71};
    int fld_wd [8] = '{10, 8, 1, 24, 11, 8, 9, 1};

    function automatic logic [dda_pkg::OUT_W-1:0] cast_ray(logic [9:0] col);
        longint w, camx, rx, ry, tx, ty, sx, sy, fx, fy, dx, dy, totx, toty;
        longint dst, ht, hp, t, br;
        bit vx, vy, side, outside;
        logic [7:0] wall;
        logic [dda_pkg::OUT_W-1:0] r;
        dx = 0; dy = 0; totx = 0; toty = 0; side = 0; outside = 0; wall = 0;
        w = (scr_w == 0) ? 1 : longint'(scr_w);
        camx = (2 * longint'(col) * 65536) / w - 65536;
        rx = longint'(dirx) + ((longint'(plx) * camx) >>> 16);
        ry = longint'(diry) + ((longint'(ply) * camx) >>> 16);
        vx = rx != 0;
        vy = ry != 0;
        tx = px >> 16;
        ty = py >> 16;
        fx = px & 16'hFFFF;
        fy = py & 16'hFFFF;
        sx = rx > 0 ? 1 : -1;
        sy = ry > 0 ? 1 : -1;
        if (vx) begin
            dx = (64'd1 << 30) / (rx < 0 ? -rx : rx);
            totx = ((rx > 0 ? 65536 - fx : fx) * dx) >> 16;
        end
        if (vy) begin
            dy = (64'd1 << 30) / (ry < 0 ? -ry : ry);
            toty = ((ry > 0 ? 65536 - fy : fy) * dy) >> 16;
        end
        if ((!vx && !vy) || tx >= dda_pkg::MAP_SIZE || ty >= dda_pkg::MAP_SIZE) outside = 1;
        while (!outside) begin
            if (vx && (!vy || totx < toty)) begin
                totx += dx; tx += sx; side = 0;
            end else begin
                toty += dy; ty += sy; side = 1;
            end
            if (tx < 0 || ty < 0 || tx >= dda_pkg::MAP_SIZE || ty >= dda_pkg::MAP_SIZE) begin
                outside = 1;
                break;
            end
            wall = tiles[ty * dda_pkg::MAP_SIZE + tx];
            if (wall != 0) break;
        end
        r = '0;
        r[9:0] = col;
        if (outside) begin
            r[71] = 1'b1;
            return r;
        end
        dst = side ? toty - dy : totx - dx;
        if (dst > 24'hFFFFFF) dst = 24'hFFFFFF;
        ht = (longint'(scr_h) << 16) / (dst > 65536 ? dst : 65536);
        if (side) hp = longint'(px) + ((rx * dst) >>> 14);
        else hp = longint'(py) + ((ry * dst) >>> 14);
        t = (longint'(dda_pkg::MAP_SIZE + 1) << 16) - dst;
        if (t < 0) t = -t;
        br = (t * t) / ((longint'(dda_pkg::MAP_SIZE) * dda_pkg::MAP_SIZE) << 24);
        if (br > 256) br = 256;
        r[17:10] = wall;
        r[18] = side;
        r[42:19] = dst[23:0];
        r[53:43] = ht[10:0];
        r[61:54] = hp[15:8];
        r[70:62] = br[8:0];
        return r;
    endfunction

    // sender
    t_cmd cur;
    int s_gap = 0;
    always @(posedge i_clk) begin
        logic nv;
        nv = i_s_tvalid;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                if (cur.act == dda_pkg::ACT_WRITE) tiles[{cur.ty, cur.tx}] = cur.val;
                else hit_q = {hit_q, cast_ray(cur.col)};
                s_gap = no_idle ? 0 : $urandom_range(0, 18);
                nv = 1'b0;
            end
            if (!nv) begin
                if (s_gap > 0) s_gap--;
                else if (cmd_q.size() > 0) begin
                    cur = cmd_q.pop_front();
                    i_s_tdata <= {2'b0, cur.col, cur.val, cur.ty, cur.tx};
                    i_s_tuser <= cur.act;
                    nv = 1'b1;
                end
            end
        end
        i_s_tvalid <= nv;
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 2500;
        end else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // receiver and checker
    int m_stall = 0;
    always @(posedge i_clk) begin
        logic [dda_pkg::OUT_W-1:0] want;
        logic [dda_pkg::OUT_W-1:0] fe, fa;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = hit_q.pop_front();
                for (int k = 0; k < 8; k++) begin
                    fe = (want >> fld_lo[k]) & ((72'd1 << fld_wd[k]) - 1);
                    fa = (o_m_tdata >> fld_lo[k]) & ((72'd1 << fld_wd[k]) - 1);
                    if (fe !== fa) begin
                        $display("%0t: field at bit %0d expected %0d got %0d",
                                 $time, fld_lo[k], fe, fa);
                        errors++;
                    end
                end
            end
            m_stall = no_idle ? 0 : $urandom_range(0, 18);
        end
        if (m_stall > 0 && !(i_rst_n && o_m_tvalid && i_m_tready)) m_stall--;
        i_m_tready <= i_rst_n && m_stall == 0 && hold_cnt == 0;
    end

    // watchdog
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 10000) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic cfg_write(logic [dda_pkg::CIDX_W-1:0] idx,
                             logic [dda_pkg::CDAT_W-1:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dda_pkg::CFG_PLAYER_X: px = d;
            dda_pkg::CFG_PLAYER_Y: py = d;
            dda_pkg::CFG_DIR_X:    dirx = d[15:0];
            dda_pkg::CFG_DIR_Y:    diry = d[15:0];
            dda_pkg::CFG_PLANE_X:  plx = d[15:0];
            dda_pkg::CFG_PLANE_Y:  ply = d[15:0];
            dda_pkg::CFG_SCR_W:    scr_w = d[10:0];
            dda_pkg::CFG_SCR_H:    scr_h = d[10:0];
            default: ;
        endcase
    endtask

    task automatic set_view(logic [21:0] x, logic [21:0] y, logic [15:0] dx_,
                            logic [15:0] dy_, logic [15:0] qx, logic [15:0] qy,
                            logic [10:0] w, logic [10:0] h);
        cfg_write(dda_pkg::CFG_PLAYER_X, x);
        cfg_write(dda_pkg::CFG_PLAYER_Y, y);
        cfg_write(dda_pkg::CFG_DIR_X, 22'(dx_));
        cfg_write(dda_pkg::CFG_DIR_Y, 22'(dy_));
        cfg_write(dda_pkg::CFG_PLANE_X, 22'(qx));
        cfg_write(dda_pkg::CFG_PLANE_Y, 22'(qy));
        cfg_write(dda_pkg::CFG_SCR_W, 22'(w));
        cfg_write(dda_pkg::CFG_SCR_H, 22'(h));
    endtask

    task automatic put_tile(int x, int y, int v);
        t_cmd c;
        c = '0;
        c.act = dda_pkg::ACT_WRITE; c.tx = 6'(x); c.ty = 6'(y); c.val = 8'(v);
        c.col = 10'($urandom);
        cmd_q = {cmd_q, c};
    endtask

    task automatic put_cast(int col);
        t_cmd c;
        c = '0;
        c.act = dda_pkg::ACT_CAST; c.col = 10'(col);
        c.tx = 6'($urandom); c.ty = 6'($urandom); c.val = 8'($urandom);
        cmd_q = {cmd_q, c};
    endtask

    // sampled on the falling edge, after the sender has settled
    task automatic drain();
        while (cmd_q.size() > 0 || i_s_tvalid || hit_q.size() > 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_vec();
        // mostly moderate, sometimes full range
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 40000)) - 20000);
    endfunction

    initial begin
        int w;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // room walls first, sparse inside; rays never get past the walls
        no_idle = 1;
        for (int y = ROOM_LO; y <= ROOM_HI; y++)
            for (int x = ROOM_LO; x <= ROOM_HI; x++)
                if (x == ROOM_LO || y == ROOM_LO || x == ROOM_HI || y == ROOM_HI)
                    put_tile(x, y, $urandom_range(1, 255));
                else
                    put_tile(x, y, ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 255));
        drain();
        no_idle = 0;

        // directed: reset view, column extremes, value extremes
        put_cast(0); put_cast(639); put_cast(1023); put_cast(320);
        put_tile(34, 32, 255); put_cast(320);
        put_tile(34, 32, 0); put_cast(320);
        drain();
        // degenerate ray, then zero y axis
        set_view(22'h200000, 22'h200000, 0, 0, 0, 0, 1024, 1024);
        put_cast(0); put_cast(512);
        drain();
        set_view(22'h208000, 22'h208000, 16'h8000, 0, 16'h7FFF, 0, 0, 1);
        put_cast(0); put_cast(1023);
        drain();
        // on the border tile looking out: leaves the map
        set_view(22'h00_8000, 22'h3F_FFFF, 16'h8000, 16'h7FFF, 0, 0, 1, 1024);
        put_cast(0);
        drain();
        set_view(0, 0, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1024, 2047);
        put_cast(0); put_cast(1023); put_cast(512);
        drain();

        // random phases, player and tile writes inside the room
        for (int ph = 0; ph < 12; ph++) begin
            w = $urandom_range(1, 1024);
            set_view(22'($urandom_range((ROOM_LO + 1) * 65536, ROOM_HI * 65536 - 1)),
                     22'($urandom_range((ROOM_LO + 1) * 65536, ROOM_HI * 65536 - 1)),
                     rnd_vec(), rnd_vec(), rnd_vec(), rnd_vec(), 11'(w),
                     11'($urandom_range(1, 1024)));
            no_idle = (ph % 4 == 3);
            if (ph == 5) hold_req = ~hold_req;
            for (int n = 0; n < 60; n++) begin
                if ($urandom_range(0, 4) == 0)
                    put_tile($urandom_range(ROOM_LO + 1, ROOM_HI - 1),
                             $urandom_range(ROOM_LO + 1, ROOM_HI - 1),
                             ($urandom_range(0, 1)) ? 0 : $urandom_range(0, 255));
                else
                    put_cast($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, w - 1));
            end
            drain();
        end
        repeat (400) @(posedge i_clk);
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule
